FILE: rtl/ppp_pkg.sv
// Shared constants and types for the pinhole point projection block.
// No dependencies; imported by every module of the block.
package ppp_pkg;

  localparam int NUM_REGS  = 6;
  localparam int REG_W     = 64;
  localparam int IDX_W     = 3;
  localparam int COEF_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int OUT_W     = 32;
  localparam int QBITS     = 33;   // quotient bits 32..0, bit 32 flags overflow
  localparam int DEF_COORD_WIDTH = 32;
  // product, row sum, magnitude, divider cells, output
  localparam int LATENCY   = 3 + QBITS + 1;

  localparam logic [IDX_W-1:0] REG_ROW0_01 = 3'd0;
  localparam logic [IDX_W-1:0] REG_ROW0_23 = 3'd1;
  localparam logic [IDX_W-1:0] REG_ROW1_01 = 3'd2;
  localparam logic [IDX_W-1:0] REG_ROW1_23 = 3'd3;
  localparam logic [IDX_W-1:0] REG_ROW2_01 = 3'd4;
  localparam logic [IDX_W-1:0] REG_ROW2_23 = 3'd5;

  typedef struct packed {
    logic valid;
    logic neg_x;
    logic neg_y;
    logic zero;
  } ctl_t;

endpackage

FILE: rtl/ppp_row_sum.sv
// One matrix row times the homogeneous point: products, then exact sum.
// Depends on ppp_pkg.
module ppp_row_sum #(
  parameter int COORD_WIDTH = ppp_pkg::DEF_COORD_WIDTH
) (
  input  logic                               clk,
  input  logic signed [ppp_pkg::COEF_W-1:0]  coef0,
  input  logic signed [ppp_pkg::COEF_W-1:0]  coef1,
  input  logic signed [ppp_pkg::COEF_W-1:0]  coef2,
  input  logic signed [ppp_pkg::COEF_W-1:0]  coef3,
  input  logic signed [COORD_WIDTH-1:0]      x,
  input  logic signed [COORD_WIDTH-1:0]      y,
  input  logic signed [COORD_WIDTH-1:0]      z,
  output logic signed [COORD_WIDTH+33:0]     sum
);
  import ppp_pkg::*;

  localparam int PW = COORD_WIDTH + COEF_W;
  localparam int SW = COORD_WIDTH + 34;

  logic signed [PW-1:0] p0, p1, p2, p3;

  // products, registered before the adder
  always_ff @(posedge clk) begin
    p0 <= coef0 * x;
    p1 <= coef1 * y;
    p2 <= coef2 * z;
    p3 <= PW'(coef3) <<< FRAC_W;
  end

  always_ff @(posedge clk) begin
    sum <= SW'(p0) + SW'(p1) + SW'(p2) + SW'(p3);
  end

endmodule

FILE: rtl/ppp_div_cell.sv
// One restoring-division cell: settles one quotient bit for both image axes.
// Depends on ppp_pkg.
module ppp_div_cell #(
  parameter int COORD_WIDTH = ppp_pkg::DEF_COORD_WIDTH,
  parameter int SHIFT       = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ppp_pkg::ctl_t                  in_ctl,
  input  logic [ppp_pkg::OUT_W-1:0]      in_dw,
  input  logic [COORD_WIDTH+33:0]        in_d,
  input  logic [COORD_WIDTH+49:0]        in_rx,
  input  logic [COORD_WIDTH+49:0]        in_ry,
  input  logic [ppp_pkg::QBITS-1:0]      in_qx,
  input  logic [ppp_pkg::QBITS-1:0]      in_qy,
  output ppp_pkg::ctl_t                  out_ctl,
  output logic [ppp_pkg::OUT_W-1:0]      out_dw,
  output logic [COORD_WIDTH+33:0]        out_d,
  output logic [COORD_WIDTH+49:0]        out_rx,
  output logic [COORD_WIDTH+49:0]        out_ry,
  output logic [ppp_pkg::QBITS-1:0]      out_qx,
  output logic [ppp_pkg::QBITS-1:0]      out_qy
);
  import ppp_pkg::*;

  localparam int NW = COORD_WIDTH + 50;
  localparam int RW = NW + QBITS;

  logic [RW-1:0] dsh, rxe, rye;
  logic          ge_x, ge_y;

  always_comb begin
    dsh  = RW'(in_d) << SHIFT;
    rxe  = RW'(in_rx);
    rye  = RW'(in_ry);
    ge_x = rxe >= dsh;
    ge_y = rye >= dsh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    out_dw <= in_dw;
    out_d  <= in_d;
    out_rx <= ge_x ? NW'(rxe - dsh) : in_rx;
    out_ry <= ge_y ? NW'(rye - dsh) : in_ry;
    out_qx <= in_qx | (QBITS'(ge_x) << SHIFT);
    out_qy <= in_qy | (QBITS'(ge_y) << SHIFT);
  end

endmodule

FILE: rtl/pinhole_point_projection.sv
// Pinhole point projection: 3x4 camera matrix times (x, y, z, 1), then the
// first two rows divided by the third. One point per cycle sustained:
// 33 division cells (one quotient bit per cell) behind a 3-stage multiply-add.
// busy follows rst; synchronous reset clears the pipeline valid bits and the
// six coefficient registers to zero. Results cannot be stalled.
module pinhole_point_projection #(
  parameter int COORD_WIDTH = ppp_pkg::DEF_COORD_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [COORD_WIDTH-1:0]      world_x,
  input  logic signed [COORD_WIDTH-1:0]      world_y,
  input  logic signed [COORD_WIDTH-1:0]      world_z,
  input  logic                               wr_en,
  input  logic [ppp_pkg::IDX_W-1:0]          wr_index,
  input  logic [ppp_pkg::REG_W-1:0]          wr_data,
  output logic                               done,
  output logic signed [ppp_pkg::OUT_W-1:0]   image_x,
  output logic signed [ppp_pkg::OUT_W-1:0]   image_y,
  output logic signed [ppp_pkg::OUT_W-1:0]   depth_weight,
  output logic                               zero_weight
);
  import ppp_pkg::*;

  localparam int SW = COORD_WIDTH + 34;   // exact row sum
  localparam int NW = SW + FRAC_W;        // shifted numerator magnitude
  localparam int WF = SW - FRAC_W;        // weight in Q16.16, before saturation

  // Coefficient registers, to be written only while idle; the block does not enforce this.
  logic [REG_W-1:0] coef_reg [NUM_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) coef_reg[i] <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_ROW0_01: coef_reg[0] <= wr_data;
        REG_ROW0_23: coef_reg[1] <= wr_data;
        REG_ROW1_01: coef_reg[2] <= wr_data;
        REG_ROW1_23: coef_reg[3] <= wr_data;
        REG_ROW2_01: coef_reg[4] <= wr_data;
        REG_ROW2_23: coef_reg[5] <= wr_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign busy = rst;

  // Valid bits for the multiply-add front: products and sums.
  logic v1, v2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= start & ~busy;
      v2 <= v1;
    end
  end

  // Three row sums: row 0 -> image x numerator, row 1 -> y, row 2 -> weight.
  logic signed [SW-1:0] rsum [3];

  for (genvar r = 0; r < 3; r++) begin : g_row
    ppp_row_sum #(.COORD_WIDTH(COORD_WIDTH)) u_row (
      .clk   (clk),
      .coef0 (coef_reg[2*r][COEF_W-1:0]),
      .coef1 (coef_reg[2*r][REG_W-1:COEF_W]),
      .coef2 (coef_reg[2*r+1][COEF_W-1:0]),
      .coef3 (coef_reg[2*r+1][REG_W-1:COEF_W]),
      .x     (world_x),
      .y     (world_y),
      .z     (world_z),
      .sum   (rsum[r])
    );
  end

  // Split sums into sign and magnitude, saturate the weight, flag zero.
  logic [SW-1:0]    mag_x, mag_y, mag_w;
  logic signed [WF-1:0] wf;
  logic [OUT_W-1:0] dw_sat;
  logic             w_fits;

  always_comb begin
    mag_x  = rsum[0][SW-1] ? (~rsum[0] + 1'b1) : rsum[0];
    mag_y  = rsum[1][SW-1] ? (~rsum[1] + 1'b1) : rsum[1];
    mag_w  = rsum[2][SW-1] ? (~rsum[2] + 1'b1) : rsum[2];
    wf     = rsum[2][SW-1:FRAC_W];  // floor to Q16.16
    w_fits = (&wf[WF-1:OUT_W-1]) | ~(|wf[WF-1:OUT_W-1]);
    if (w_fits)         dw_sat = wf[OUT_W-1:0];
    else if (wf[WF-1])  dw_sat = {1'b1, {(OUT_W-1){1'b0}}};
    else                dw_sat = {1'b0, {(OUT_W-1){1'b1}}};
  end

  // Divider chain: stage 0 is the loaded operand set, stage k+1 is cell k out.
  ctl_t             c_ctl [QBITS+1];
  logic [OUT_W-1:0] c_dw  [QBITS+1];
  logic [SW-1:0]    c_d   [QBITS+1];
  logic [NW-1:0]    c_rx  [QBITS+1];
  logic [NW-1:0]    c_ry  [QBITS+1];
  logic [QBITS-1:0] c_qx  [QBITS+1];
  logic [QBITS-1:0] c_qy  [QBITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_ctl[0] <= '0;
    end else begin
      c_ctl[0].valid <= v2;
      c_ctl[0].neg_x <= rsum[0][SW-1] ^ rsum[2][SW-1];
      c_ctl[0].neg_y <= rsum[1][SW-1] ^ rsum[2][SW-1];
      c_ctl[0].zero  <= ~(|rsum[2]);
    end
  end

  always_ff @(posedge clk) begin
    c_dw[0] <= dw_sat;
    c_d[0]  <= mag_w;
    c_rx[0] <= {mag_x, {FRAC_W{1'b0}}};
    c_ry[0] <= {mag_y, {FRAC_W{1'b0}}};
    c_qx[0] <= '0;
    c_qy[0] <= '0;
  end

  // Cell k settles quotient bit QBITS-1-k; the top bit catches overflow.
  for (genvar k = 0; k < QBITS; k++) begin : g_cell
    ppp_div_cell #(.COORD_WIDTH(COORD_WIDTH), .SHIFT(QBITS - 1 - k)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .in_ctl  (c_ctl[k]),
      .in_dw   (c_dw[k]),
      .in_d    (c_d[k]),
      .in_rx   (c_rx[k]),
      .in_ry   (c_ry[k]),
      .in_qx   (c_qx[k]),
      .in_qy   (c_qy[k]),
      .out_ctl (c_ctl[k+1]),
      .out_dw  (c_dw[k+1]),
      .out_d   (c_d[k+1]),
      .out_rx  (c_rx[k+1]),
      .out_ry  (c_ry[k+1]),
      .out_qx  (c_qx[k+1]),
      .out_qy  (c_qy[k+1])
    );
  end

  // Apply sign and saturate the quotients; zero weight forces zero.
  logic [QBITS-1:0] qx_f, qy_f;
  logic [OUT_W-1:0] img_x_next, img_y_next;
  ctl_t             fctl;

  always_comb begin
    fctl = c_ctl[QBITS];
    qx_f = c_qx[QBITS];
    qy_f = c_qy[QBITS];
    if (fctl.zero) begin
      img_x_next = '0;
    end else if (!fctl.neg_x) begin
      img_x_next = (qx_f[QBITS-1] | qx_f[OUT_W-1]) ? {1'b0, {(OUT_W-1){1'b1}}}
                                                   : qx_f[OUT_W-1:0];
    end else begin
      img_x_next = (qx_f[QBITS-1] | (qx_f[OUT_W-1] & (|qx_f[OUT_W-2:0])))
                   ? {1'b1, {(OUT_W-1){1'b0}}} : (~qx_f[OUT_W-1:0] + 1'b1);
    end
    if (fctl.zero) begin
      img_y_next = '0;
    end else if (!fctl.neg_y) begin
      img_y_next = (qy_f[QBITS-1] | qy_f[OUT_W-1]) ? {1'b0, {(OUT_W-1){1'b1}}}
                                                   : qy_f[OUT_W-1:0];
    end else begin
      img_y_next = (qy_f[QBITS-1] | (qy_f[OUT_W-1] & (|qy_f[OUT_W-2:0])))
                   ? {1'b1, {(OUT_W-1){1'b0}}} : (~qy_f[OUT_W-1:0] + 1'b1);
    end
  end

  // Result beat: strobe done for one cycle with the payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    image_x      <= img_x_next;
    image_y      <= img_y_next;
    depth_weight <= c_dw[QBITS];
    zero_weight  <= fctl.zero;
  end

endmodule

FILE: rtl/ppp_checker.sv
// Port-level checks for pinhole_point_projection, bound to the top level.
// Depends on ppp_pkg.
module ppp_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               start,
  input logic                               busy,
  input logic                               done,
  input logic signed [ppp_pkg::OUT_W-1:0]   image_x,
  input logic signed [ppp_pkg::OUT_W-1:0]   image_y,
  input logic signed [ppp_pkg::OUT_W-1:0]   depth_weight,
  input logic                               zero_weight
);
  import ppp_pkg::*;

  // every accepted beat gives exactly one result, a fixed time later
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done == $past(start && !busy, LATENCY))
    else $error("result beat does not match accepted beat");

  a_zero_img: assert property (@(posedge clk) disable iff (rst)
    (done && zero_weight) |-> (image_x == '0 && image_y == '0))
    else $error("zero weight with nonzero image coordinates");

  a_zero_dw: assert property (@(posedge clk) disable iff (rst)
    (done && zero_weight) |-> (depth_weight == '0))
    else $error("zero weight with nonzero depth weight");

  a_no_beat_reset: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result beat right after reset");

endmodule

bind pinhole_point_projection ppp_checker u_ppp_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .image_x      (image_x),
  .image_y      (image_y),
  .depth_weight (depth_weight),
  .zero_weight  (zero_weight)
);

FILE: sim/pinhole_point_projection_check.sv
// Checker for the pinhole point projection block: predicts each point's
// projection from its own copy of the matrix and compares the done beats.
// Depends on ppp_pkg for register indexes and widths.
module pinhole_point_projection_check (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  logic signed [31:0]              world_x,
  input  logic signed [31:0]              world_y,
  input  logic signed [31:0]              world_z,
  input  logic                            wr_en,
  input  logic [ppp_pkg::IDX_W-1:0]       wr_index,
  input  logic [ppp_pkg::REG_W-1:0]       wr_data,
  input  logic                            done,
  input  logic signed [31:0]              image_x,
  input  logic signed [31:0]              image_y,
  input  logic signed [31:0]              depth_weight,
  input  logic                            zero_weight,
  output int                              fail_count,
  output int                              pending
);
  import ppp_pkg::*;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] wt;
    logic               zw;
  } proj_t;

  logic [REG_W-1:0] matrix_regs [NUM_REGS];
  proj_t projections [$];

  function automatic logic signed [31:0] clamp32(logic signed [127:0] v);
    if (v > 128'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -128'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [127:0] row_dot(int row, logic signed [31:0] x,
                                                  logic signed [31:0] y,
                                                  logic signed [31:0] z);
    logic [REG_W-1:0] lo_reg;
    logic [REG_W-1:0] hi_reg;
    logic signed [127:0] acc;
    lo_reg = matrix_regs[row * 2];
    hi_reg = matrix_regs[row * 2 + 1];
    acc = 128'(x) * 128'($signed(lo_reg[31:0]));
    acc += 128'(y) * 128'($signed(lo_reg[63:32]));
    acc += 128'(z) * 128'($signed(hi_reg[31:0]));
    acc += 128'(hi_reg[63:32] == 0 ? 0 : $signed(hi_reg[63:32])) <<< 16;
    return acc;
  endfunction

  // Divide in magnitudes so the quotient truncates toward zero.
  function automatic logic signed [31:0] ratio(logic signed [127:0] num,
                                               logic signed [127:0] den);
    logic [127:0] nm;
    logic [127:0] dm;
    logic [127:0] q;
    nm = num < 0 ? -num : num;
    dm = den < 0 ? -den : den;
    q = (nm << 16) / dm;
    if ((num < 0) != (den < 0)) return clamp32(-$signed(q));
    return clamp32($signed(q));
  endfunction

  function automatic proj_t project_point(logic signed [31:0] x, logic signed [31:0] y,
                                          logic signed [31:0] z);
    logic signed [127:0] r0;
    logic signed [127:0] r1;
    logic signed [127:0] w;
    proj_t p;
    r0 = row_dot(0, x, y, z);
    r1 = row_dot(1, x, y, z);
    w = row_dot(2, x, y, z);
    p.wt = clamp32(w >>> 16);
    p.zw = (w == 0);
    p.px = p.zw ? 32'sd0 : ratio(r0, w);
    p.py = p.zw ? 32'sd0 : ratio(r1, w);
    return p;
  endfunction

  assign pending = projections.size();

  always @(posedge clk) begin
    proj_t e;
    if (rst) begin
      foreach (matrix_regs[i]) matrix_regs[i] <= '0;
      fail_count <= 0;
      projections.delete();
    end else begin
      if (start && !busy)
        projections.insert(projections.size(), project_point(world_x, world_y, world_z));
      if (wr_en && wr_index < NUM_REGS) matrix_regs[wr_index] <= wr_data;
      if (done) begin
        if (projections.size() == 0) begin
          $display("%0t: done beat with nothing expected, got x=%h y=%h w=%h z=%b",
                   $time, image_x, image_y, depth_weight, zero_weight);
          fail_count <= fail_count + 1;
        end else begin
          e = projections.pop_front();
          if (e.px !== image_x || e.py !== image_y || e.wt !== depth_weight ||
              e.zw !== zero_weight) begin
            $display("%0t: mismatch expected x=%h y=%h w=%h z=%b got x=%h y=%h w=%h z=%b",
                     $time, e.px, e.py, e.wt, e.zw,
                     image_x, image_y, depth_weight, zero_weight);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

FILE: sim/pinhole_point_projection_test.sv
// Top of the pinhole point projection testbench: clock, reset, matrix
// writes, point stimulus and verdict. Depends on ppp_pkg, the block and
// pinhole_point_projection_check.
module pinhole_point_projection_test;
  import ppp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic signed [31:0] world_x = 0;
  logic signed [31:0] world_y = 0;
  logic signed [31:0] world_z = 0;
  logic wr_en = 0;
  logic [IDX_W-1:0] wr_index = REG_ROW0_01;
  logic [REG_W-1:0] wr_data = 0;
  logic done;
  logic signed [31:0] image_x;
  logic signed [31:0] image_y;
  logic signed [31:0] depth_weight;
  logic zero_weight;
  int fail_count;
  int pending;
  int cycles = 0;

  always #1 clk = ~clk;

  pinhole_point_projection i_dut (
    .clk, .rst, .start, .busy, .world_x, .world_y, .world_z,
    .wr_en, .wr_index, .wr_data, .done, .image_x, .image_y,
    .depth_weight, .zero_weight
  );

  pinhole_point_projection_check i_check (
    .clk, .rst, .start, .busy, .world_x, .world_y, .world_z,
    .wr_en, .wr_index, .wr_data, .done, .image_x, .image_y,
    .depth_weight, .zero_weight, .fail_count, .pending
  );

  // Hard stop for a hung pipeline.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("pinhole_point_projection_test NOT OK");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 3);
      3, 4, 5: return {{12{1'b0}}, 20'($urandom)} - 32'h00080000;
      default: return $urandom;
    endcase
  endfunction

  // Moderate and full-range random coefficients, with extremes and zeros mixed in.
  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 0;
      3, 4, 5: return {{10{1'b0}}, 22'($urandom)} - 32'h00200000;
      default: return $urandom;
    endcase
  endfunction

  // Write one matrix register; only done while the pipeline is drained.
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
    @(negedge clk);
    wr_en <= 1;
    wr_index <= idx;
    wr_data <= val;
    @(negedge clk);
    wr_en <= 0;
  endtask

  // Wait for every expected beat, then a pipeline's worth of cycles.
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // Hold start for one beat; idle gaps, mostly short, some long.
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit gaps);
    int gap;
    gap = !gaps ? 0 : ($urandom_range(0, 15) == 0 ? $urandom_range(5, 40)
                                                   : $urandom_range(0, 2));
    if (gap != 0) begin
      start <= 0;
      repeat (gap) @(negedge clk);
    end
    start <= 1;
    world_x <= x;
    world_y <= y;
    world_z <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_matrix(int mode);
    logic [31:0] c [12];
    foreach (c[i]) begin
      case (mode)
        0: c[i] = rand_coef();
        1: c[i] = i[0] ? 32'h80000000 : 32'h7FFFFFFF;
        2: c[i] = 0;
        default: c[i] = (i == 0 || i == 5) ? 32'h00010000 : (i == 10 ? 32'h00010000 : 0);
      endcase
    end
    // Occasionally zero the weight row so every weight is zero.
    if (mode == 0 && $urandom_range(0, 7) == 0) for (int i = 8; i < 12; i++) c[i] = 0;
    for (int r = 0; r < NUM_REGS; r++) write_reg(r[IDX_W-1:0], {c[2*r+1], c[2*r]});
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: identity-like camera, z as weight.
    load_matrix(3);
    send_point(32'h00010000, 32'h00020000, 32'h00010000, 0);
    send_point(32'h7FFFFFFF, 32'h80000000, 32'h00000001, 0);
    send_point(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 0);
    send_point(32'h00050000, 32'hFFFB0000, 32'h00000000, 0);
    send_point(32'h12345678, 32'h87654321, 32'h00000002, 0);
    send_point(32'h00010000, 32'h00010000, 32'h80000000, 0);
    send_point(32'h00000000, 32'h00000000, 32'h7FFFFFFF, 0);
    start <= 0;
    drain();

    // Extreme coefficients, alternating between the largest and smallest values.
    load_matrix(1);
    send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0);
    send_point(32'h80000000, 32'h80000000, 32'h80000000, 0);
    send_point(32'h80000000, 32'h7FFFFFFF, 32'h00000000, 0);
    send_point(32'h00000000, 32'h00000000, 32'h00000000, 0);
    start <= 0;
    drain();

    // All-zero matrix: every weight is zero.
    load_matrix(2);
    send_point(32'hFFFFFFFF, 32'h00000001, 32'h7FFFFFFF, 0);
    send_point(32'h80000000, 32'h80000000, 32'h80000000, 0);
    start <= 0;
    drain();

    // Random phases under random matrices.
    for (int ph = 0; ph < 17; ph++) begin
      load_matrix(0);
      for (int n = 0; n < 100; n++)
        send_point(rand_coord(), rand_coord(), rand_coord(), ph % 4 != 1);
      start <= 0;
      // Hold off until every expected beat has come.
      drain();
    end

    drain();
    if (fail_count == 0) begin
      $display("pinhole_point_projection_test OK");
    end else begin
      $display("pinhole_point_projection_test NOT OK");
    end
    $finish;
  end
endmodule

FILE: files.f
rtl/ppp_pkg.sv
rtl/ppp_row_sum.sv
rtl/ppp_div_cell.sv
rtl/pinhole_point_projection.sv
rtl/ppp_checker.sv
sim/pinhole_point_projection_check.sv
sim/pinhole_point_projection_test.sv
